// ----- sv/sma_pkg.sv -----
// ----------------------------------------------------------------------------
// sma_pkg: shared types and constants for the STUN mapped-address extractor
// Byte stream item, result record, attribute codes and header constants.
// ----------------------------------------------------------------------------
package sma_pkg;

  localparam logic [31:0] STUN_COOKIE   = 32'h2112A442;
  localparam logic [15:0] TYPE_MAPPED   = 16'h0001;
  localparam logic [15:0] TYPE_XOR      = 16'h0020;
  localparam logic [15:0] TYPE_MS_XOR   = 16'h8020;
  localparam logic [16:0] HEADER_BYTES  = 17'd20;
  localparam logic [16:0] POS_MAX       = 17'h1FFFF;

  localparam logic [1:0] SRC_MAPPED = 2'd0;
  localparam logic [1:0] SRC_MS_XOR = 2'd1;
  localparam logic [1:0] SRC_XOR    = 2'd2;
  localparam logic [1:0] SRC_NONE   = 2'd3;

  localparam logic [1:0] STATUS_FOUND    = 2'd0;
  localparam logic [1:0] STATUS_NOT_STUN = 2'd1;
  localparam logic [1:0] STATUS_NO_ADDR  = 2'd2;

  localparam int OUT_TDATA_W = 56;

  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } item_t;

  // packed from the low bit up: status, ip, port, source, truncated
  typedef struct packed {
    logic        truncated;
    logic [1:0]  source;
    logic [15:0] port;
    logic [31:0] ip;
    logic [1:0]  status;
  } result_t;

  function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
    logic [7:0] b;
    b = '0;
    case (idx)
      2'd0:    b = STUN_COOKIE[31:24];
      2'd1:    b = STUN_COOKIE[23:16];
      2'd2:    b = STUN_COOKIE[15:8];
      default: b = STUN_COOKIE[7:0];
    endcase
    return b;
  endfunction

endpackage

// ----- sv/stun_mapped_address_extractor.sv -----
// ----------------------------------------------------------------------------
// stun_mapped_address_extractor: STUN header check and mapped address decode
// Byte-wide stream in, one result transaction per packet out.
// ----------------------------------------------------------------------------
// Takes one payload byte per cycle while the input is not stalled, and gives
// one result on the byte marked tlast. A byte is held in the input register
// and then folded into the packet state; the result register is loaded as the
// last byte leaves the input register. The input stalls only while a last byte
// waits in the input register behind a previous result that is still waiting
// on m_tready. cfg_data sets the family byte treated as IPv4 (reset 1); write
// it between packets.
module stun_mapped_address_extractor (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // payload_byte
  input  logic                            s_tlast,   // end_of_packet
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [1:0] status, [33:2] mapped_ip, [49:34] mapped_port,
  // [51:50] address_source, [52] attribute_truncated, [55:53] zero
  output logic [sma_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [7:0]                      cfg_data   // ipv4_family_code
);
  import sma_pkg::*;

  logic       in_valid;
  item_t      item;
  logic       advance;
  result_t    result;
  logic [7:0] family_code;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      family_code <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      family_code <= cfg_data;
    end
  end

  assign advance = in_valid && (!item.last || !m_tvalid || m_tready);

  sma_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .advance  (advance),
    .in_valid (in_valid),
    .item     (item)
  );

  sma_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .item        (item),
    .family_code (family_code),
    .result      (result)
  );

  sma_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && item.last),
    .result   (result),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] != 2'd3)
    else $error("reserved status code on output");

  a_no_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] != STATUS_FOUND) |-> m_tdata[51:2] == '0)
    else $error("address fields nonzero without an address");

  a_bad_hdr_trunc: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] == STATUS_NOT_STUN) |-> !m_tdata[52])
    else $error("truncation flagged on a bad header");

  a_source_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[51:50] != SRC_NONE)
    else $error("no-source code on output");

  a_last_stall: assert property (@(posedge clk) disable iff (rst)
    (in_valid && item.last && m_tvalid && !m_tready) |-> !advance)
    else $error("last byte consumed while result register is full");

endmodule

// ----- sv/sma_in_stage.sv -----
// ----------------------------------------------------------------------------
// sma_in_stage: input register
// Holds one accepted byte until the parser consumes it.
// ----------------------------------------------------------------------------
module sma_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [7:0]     s_tdata,   // payload_byte
  input  logic           s_tlast,   // end_of_packet
  input  logic           advance,
  output logic           in_valid,
  output sma_pkg::item_t item
);
  import sma_pkg::*;

  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.data <= s_tdata;
      item.last <= s_tlast;
    end
  end

endmodule

// ----- sv/sma_parser.sv -----
// ----------------------------------------------------------------------------
// sma_parser: per-byte header check and attribute walk
// Updates packet state for one byte and forms the result on the last byte.
// ----------------------------------------------------------------------------
module sma_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  sma_pkg::item_t   item,
  input  logic [7:0]       family_code,
  output sma_pkg::result_t result
);
  import sma_pkg::*;

  logic [16:0] pos, pos_next;
  logic [15:0] msg_len, msg_len_next;
  logic [15:0] remaining, remaining_next;
  logic [15:0] attr_type, attr_type_next;
  logic [15:0] attr_len, attr_len_next;
  logic [16:0] attr_off, attr_off_next;
  logic [7:0]  family, family_next;
  logic [15:0] raw_port, raw_port_next;
  logic [31:0] raw_ip, raw_ip_next;
  logic [1:0]  best_src, best_src_next;
  logic [31:0] held_ip, held_ip_next;
  logic [15:0] held_port, held_port_next;
  logic        header_bad, header_bad_next;
  logic        walk_stopped, walk_stopped_next;

  logic [7:0]  b;
  logic        walk_en;
  logic        is_addr;
  logic [1:0]  src;
  logic        addr_ok;
  logic [31:0] cand_ip;
  logic [16:0] count;
  logic        not_stun;

  assign b = item.data;
  assign walk_en = (pos >= HEADER_BYTES) && !header_bad && !walk_stopped
                   && (remaining != 16'd0);
  assign cand_ip = {raw_ip[23:0], b};

  always_comb begin
    is_addr = 1'b1;
    src     = SRC_MAPPED;
    unique case (attr_type)
      TYPE_MAPPED: src = SRC_MAPPED;
      TYPE_MS_XOR: src = SRC_MS_XOR;
      TYPE_XOR:    src = SRC_XOR;
      default:     is_addr = 1'b0;
    endcase
  end

  assign addr_ok = is_addr && ((best_src == SRC_NONE) || (src >= best_src))
                   && (family == family_code);

  always_comb begin
    pos_next          = pos;
    msg_len_next      = msg_len;
    remaining_next    = remaining;
    attr_type_next    = attr_type;
    attr_len_next     = attr_len;
    attr_off_next     = attr_off;
    family_next       = family;
    raw_port_next     = raw_port;
    raw_ip_next       = raw_ip;
    best_src_next     = best_src;
    held_ip_next      = held_ip;
    held_port_next    = held_port;
    header_bad_next   = header_bad;
    walk_stopped_next = walk_stopped;
    if (step) begin
      if (pos == 17'd2 || pos == 17'd3) msg_len_next = {msg_len[7:0], b};
      if (pos == 17'd3) remaining_next = {msg_len[7:0], b};
      if (pos >= 17'd4 && pos < 17'd8 && b != cookie_byte(pos[1:0])) begin
        header_bad_next = 1'b1;
      end
      if (walk_en) begin
        if (attr_off == 17'd0 && remaining < 16'd4) begin
          walk_stopped_next = 1'b1;
        end else begin
          if (attr_off < 17'd2) begin
            attr_type_next = {attr_type[7:0], b};
          end else if (attr_off < 17'd4) begin
            attr_len_next = {attr_len[7:0], b};
          end else if (attr_off == 17'd5) begin
            family_next = b;
          end else if (attr_off == 17'd6 || attr_off == 17'd7) begin
            raw_port_next = {raw_port[7:0], b};
          end else if (attr_off >= 17'd8 && attr_off < 17'd12) begin
            raw_ip_next = cand_ip;
          end
          if (attr_off == 17'd3 &&
              ({1'b0, attr_len_next} + 17'd4) > {1'b0, remaining}) begin
            walk_stopped_next = 1'b1;
          end else begin
            if (attr_off == 17'd11 && addr_ok) begin
              best_src_next = src;
              if (src == SRC_MAPPED) begin
                held_ip_next   = cand_ip;
                held_port_next = raw_port;
              end else begin
                held_ip_next   = cand_ip ^ STUN_COOKIE;
                held_port_next = raw_port ^ STUN_COOKIE[31:16];
              end
            end
            if (attr_off >= 17'd3 && attr_off == ({1'b0, attr_len_next} + 17'd3)) begin
              remaining_next = remaining - attr_len_next - 16'd4;
              attr_off_next  = '0;
              attr_type_next = '0;
              attr_len_next  = '0;
              family_next    = '0;
              raw_port_next  = '0;
              raw_ip_next    = '0;
            end else begin
              attr_off_next = attr_off + 17'd1;
            end
          end
        end
      end
      pos_next = (pos == POS_MAX) ? pos : pos + 17'd1;
    end
  end

  assign count    = pos_next;
  assign not_stun = (count < HEADER_BYTES) || header_bad_next ||
                    ({1'b0, msg_len_next} > (count - HEADER_BYTES));

  always_comb begin
    result = '0;
    if (not_stun) begin
      result.status = STATUS_NOT_STUN;
    end else begin
      result.truncated = walk_stopped_next;
      if (best_src_next == SRC_NONE) begin
        result.status = STATUS_NO_ADDR;
      end else begin
        result.status = STATUS_FOUND;
        result.ip     = held_ip_next;
        result.port   = held_port_next;
        result.source = best_src_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.last)) begin
      pos          <= '0;
      msg_len      <= '0;
      remaining    <= '0;
      attr_type    <= '0;
      attr_len     <= '0;
      attr_off     <= '0;
      family       <= '0;
      raw_port     <= '0;
      raw_ip       <= '0;
      best_src     <= SRC_NONE;
      held_ip      <= '0;
      held_port    <= '0;
      header_bad   <= 1'b0;
      walk_stopped <= 1'b0;
    end else begin
      pos          <= pos_next;
      msg_len      <= msg_len_next;
      remaining    <= remaining_next;
      attr_type    <= attr_type_next;
      attr_len     <= attr_len_next;
      attr_off     <= attr_off_next;
      family       <= family_next;
      raw_port     <= raw_port_next;
      raw_ip       <= raw_ip_next;
      best_src     <= best_src_next;
      held_ip      <= held_ip_next;
      held_port    <= held_port_next;
      header_bad   <= header_bad_next;
      walk_stopped <= walk_stopped_next;
    end
  end

endmodule

// ----- sv/sma_out_stage.sv -----
// ----------------------------------------------------------------------------
// sma_out_stage: result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module sma_out_stage (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  sma_pkg::result_t                  result,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // status, mapped_ip, mapped_port, address_source, attribute_truncated, pad
  output logic [sma_pkg::OUT_TDATA_W-1:0]   m_tdata
);
  import sma_pkg::*;

  localparam int PAD_W = OUT_TDATA_W - $bits(result_t);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {{PAD_W{1'b0}}, result};
    end
  end

endmodule

// ----- tb/tb_stun_mapped_address_extractor.sv -----
// ----------------------------------------------------------------------------
// tb_stun_mapped_address_extractor: self-checking bench for the STUN extractor
// Streams STUN and non-STUN payloads byte by byte, predicts the per-packet
// result transaction in a cycle-free parser model and checks every result field.
// ----------------------------------------------------------------------------
module tb_stun_mapped_address_extractor;
  import sma_pkg::*;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [7:0]             s_tdata   = '0;
  logic                   s_tlast   = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [7:0]             cfg_data  = '0;

  stun_mapped_address_extractor dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("[stun_mapped_address_extractor] ERROR");
    $finish;
  end

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors        = 0;

  result_t    reports_due[$];
  logic [7:0] pkt[$];

  // parser state
  logic [7:0]  fam_code;
  logic [16:0] pos;
  logic [31:0] cookie;
  logic [15:0] msg_len, remain, atype, alen;
  logic [16:0] aoff;
  logic [7:0]  fam;
  logic [15:0] rport;
  logic [31:0] rip;
  logic [1:0]  best;
  logic [31:0] hip;
  logic [15:0] hport;
  logic        hdr_bad, stopped;

  task automatic clear_parse();
    pos = '0; cookie = '0; msg_len = '0; remain = '0; atype = '0; alen = '0;
    aoff = '0; fam = '0; rport = '0; rip = '0; best = SRC_NONE;
    hip = '0; hport = '0; hdr_bad = 1'b0; stopped = 1'b0;
  endtask

  task automatic weigh_address();
    logic [1:0] src;
    if (atype == TYPE_MAPPED) src = SRC_MAPPED;
    else if (atype == TYPE_MS_XOR) src = SRC_MS_XOR;
    else if (atype == TYPE_XOR) src = SRC_XOR;
    else return;
    if (best != SRC_NONE && src < best) return;
    if (fam != fam_code) return;
    best = src;
    if (src == SRC_MAPPED) begin
      hip   = rip;
      hport = rport;
    end else begin
      hip   = rip ^ cookie;
      hport = rport ^ cookie[31:16];
    end
  endtask

  task automatic walk_attr_byte(input logic [7:0] b);
    int off;
    off = int'(aoff);
    if (off == 0 && remain < 16'd4) begin
      stopped = 1'b1;
      return;
    end
    if (off < 2) atype = {atype[7:0], b};
    else if (off < 4) alen = {alen[7:0], b};
    else if (off == 5) fam = b;
    else if (off == 6 || off == 7) rport = {rport[7:0], b};
    else if (off >= 8 && off < 12) rip = {rip[23:0], b};
    if (off == 3 && int'(alen) + 4 > int'(remain)) begin
      stopped = 1'b1;
      return;
    end
    if (off == 11) weigh_address();
    if (off >= 3 && off == int'(alen) + 3) begin
      remain = remain - (alen + 16'd4);
      aoff = '0; atype = '0; alen = '0; fam = '0; rport = '0; rip = '0;
    end else begin
      aoff = aoff + 17'd1;
    end
  endtask

  task automatic parse_payload_byte(input logic [7:0] b, input logic is_last);
    result_t    r;
    logic [1:0] st;
    if (pos == 17'd2 || pos == 17'd3) msg_len = {msg_len[7:0], b};
    if (pos == 17'd3) remain = msg_len;
    if (pos >= 17'd4 && pos < 17'd8) cookie = {cookie[23:0], b};
    if (pos == 17'd7 && cookie != STUN_COOKIE) hdr_bad = 1'b1;
    if (pos >= HEADER_BYTES && !hdr_bad && !stopped && remain != 16'd0)
      walk_attr_byte(b);
    if (pos < POS_MAX) pos = pos + 17'd1;
    if (!is_last) return;
    if (pos < HEADER_BYTES || hdr_bad || {1'b0, msg_len} > pos - HEADER_BYTES)
      st = STATUS_NOT_STUN;
    else if (best == SRC_NONE)
      st = STATUS_NO_ADDR;
    else
      st = STATUS_FOUND;
    r = '0;
    r.status = st;
    if (st == STATUS_FOUND) begin
      r.ip     = hip;
      r.port   = hport;
      r.source = best;
    end
    r.truncated = (st != STATUS_NOT_STUN) && stopped;
    reports_due.push_back(r);
    clear_parse();
  endtask

  // result checking
  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    errors++;
    if (errors <= 40)
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
  endtask

  task automatic check_report(input logic [OUT_TDATA_W-1:0] data);
    result_t want, got;
    got = data[$bits(result_t)-1:0];
    if (reports_due.size() == 0) begin
      errors++;
      if (errors <= 40)
        $display("%0t: unexpected result, expected none, actual %h", $time, data);
      return;
    end
    want = reports_due.pop_front();
    if (got.status !== want.status)
      report_mismatch("status", 32'(want.status), 32'(got.status));
    if (got.ip !== want.ip) report_mismatch("mapped_ip", want.ip, got.ip);
    if (got.port !== want.port)
      report_mismatch("mapped_port", 32'(want.port), 32'(got.port));
    if (got.source !== want.source)
      report_mismatch("address_source", 32'(want.source), 32'(got.source));
    if (got.truncated !== want.truncated)
      report_mismatch("attribute_truncated", 32'(want.truncated), 32'(got.truncated));
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_report(m_tdata);
  end

  always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_idle_pct);

  // stimulus transport
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= is_last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    parse_payload_byte(b, is_last);
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (reports_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_family(input logic [7:0] code);
    wait_drained();
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= code;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    fam_code = code;
  endtask

  // packet building
  task automatic put16(input logic [15:0] v);
    pkt.push_back(v[15:8]);
    pkt.push_back(v[7:0]);
  endtask

  task automatic start_stun(input logic [31:0] magic);
    pkt = {};
    put16(16'($urandom));
    put16(16'h0000);
    put16(magic[31:16]);
    put16(magic[15:0]);
    repeat (12) pkt.push_back(8'($urandom));
  endtask

  task automatic set_msg_len(input int extra);
    logic [15:0] l;
    l = 16'(pkt.size() - 20 + extra);
    pkt[2] = l[15:8];
    pkt[3] = l[7:0];
  endtask

  task automatic put_addr(input logic [15:0] kind, input logic [7:0] family,
                          input logic [15:0] port, input logic [31:0] ip,
                          input int vlen);
    logic [7:0] v[$];
    v = {8'($urandom), family, port[15:8], port[7:0],
         ip[31:24], ip[23:16], ip[15:8], ip[7:0]};
    while (v.size() < vlen) v.push_back(8'($urandom));
    put16(kind);
    put16(16'(vlen));
    for (int i = 0; i < vlen; i++) pkt.push_back(v[i]);
  endtask

  task automatic put_blob(input logic [15:0] kind, input int vlen);
    put16(kind);
    put16(16'(vlen));
    repeat (vlen) pkt.push_back(8'($urandom));
  endtask

  task automatic put_random_attr();
    int          k;
    logic [15:0] kind;
    logic [7:0]  family;
    int          vlen;
    k = $urandom_range(9);
    if (k < 3) kind = TYPE_XOR;
    else if (k < 5) kind = TYPE_MS_XOR;
    else if (k < 7) kind = TYPE_MAPPED;
    else if (k == 7) kind = TYPE_XOR ^ (16'd1 << $urandom_range(15));
    else kind = 16'($urandom);
    family = ($urandom_range(3) != 0) ? fam_code : 8'($urandom);
    vlen = ($urandom_range(4) != 0) ? 8 : $urandom_range(14);
    if (k >= 7 && $urandom_range(1) == 1) put_blob(kind, $urandom_range(12));
    else put_addr(kind, family, 16'($urandom), $urandom, vlen);
  endtask

  task automatic build_random_packet();
    int pick;
    int n;
    int adj;
    pick = $urandom_range(99);
    if (pick < 15) begin
      pkt = {};
      n = $urandom_range(1, 30);
      repeat (n) pkt.push_back(8'($urandom));
      return;
    end
    start_stun(pick < 25 ? STUN_COOKIE ^ (32'd1 << $urandom_range(31)) : STUN_COOKIE);
    n = $urandom_range(3);
    repeat (n) put_random_attr();
    if (pick >= 25 && pick < 35) begin
      if ($urandom_range(1) == 1) begin
        put16(16'($urandom));
        put16(16'($urandom_range(5, 40)));
        repeat ($urandom_range(3)) pkt.push_back(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom));
      end
    end
    adj = 0;
    if (pick >= 35 && pick < 45) adj = int'($urandom_range(8)) - 4;
    set_msg_len(adj);
    if ($urandom_range(4) == 0) repeat ($urandom_range(1, 4)) pkt.push_back(8'($urandom));
  endtask

  // tests
  task automatic test_header_checks();
    pkt = {8'($urandom)};
    send_packet();
    start_stun(STUN_COOKIE);
    send_packet();
    start_stun(STUN_COOKIE);
    void'(pkt.pop_back());
    send_packet();
    start_stun(STUN_COOKIE ^ 32'h1);
    put_addr(TYPE_XOR, fam_code, 16'h1234, 32'h0A000001, 8);
    set_msg_len(0);
    send_packet();
    start_stun(STUN_COOKIE);
    put_addr(TYPE_XOR, fam_code, 16'h1234, 32'h0A000001, 8);
    set_msg_len(1);
    send_packet();
    start_stun(STUN_COOKIE);
    put_addr(TYPE_XOR, fam_code, 16'($urandom), $urandom, 8);
    set_msg_len(0);
    repeat (3) pkt.push_back(8'($urandom));
    send_packet();
  endtask

  task automatic test_address_attributes();
    start_stun(STUN_COOKIE);
    put_addr(TYPE_MAPPED, fam_code, 16'hFFFF, 32'hFFFFFFFF, 8);
    set_msg_len(0);
    send_packet();
    start_stun(STUN_COOKIE);
    put_addr(TYPE_MS_XOR, fam_code, 16'h0000, 32'h00000000, 8);
    set_msg_len(0);
    send_packet();
    start_stun(STUN_COOKIE);
    put_addr(TYPE_XOR, fam_code, 16'($urandom), $urandom, 8);
    put_addr(TYPE_MAPPED, fam_code, 16'($urandom), $urandom, 8);
    set_msg_len(0);
    send_packet();
    start_stun(STUN_COOKIE);
    put_addr(TYPE_MAPPED, fam_code, 16'($urandom), $urandom, 8);
    put_addr(TYPE_MS_XOR, fam_code, 16'($urandom), $urandom, 12);
    put_addr(TYPE_XOR, fam_code, 16'($urandom), $urandom, 8);
    set_msg_len(0);
    send_packet();
    start_stun(STUN_COOKIE);
    put_addr(TYPE_MAPPED, fam_code, 16'($urandom), $urandom, 8);
    put_addr(TYPE_MAPPED, fam_code, 16'($urandom), $urandom, 8);
    set_msg_len(0);
    send_packet();
    start_stun(STUN_COOKIE);
    put_addr(TYPE_XOR, fam_code, 16'($urandom), $urandom, 7);
    put_blob(16'h0006, 0);
    put_addr(TYPE_XOR, fam_code ^ 8'h02, 16'($urandom), $urandom, 8);
    set_msg_len(0);
    send_packet();
  endtask

  task automatic test_truncation();
    start_stun(STUN_COOKIE);
    put_addr(TYPE_MAPPED, fam_code, 16'($urandom), $urandom, 8);
    repeat (2) pkt.push_back(8'($urandom));
    set_msg_len(0);
    send_packet();
    start_stun(STUN_COOKIE);
    put16(16'h8022);
    put16(16'd20);
    repeat (4) pkt.push_back(8'($urandom));
    set_msg_len(0);
    send_packet();
    start_stun(STUN_COOKIE);
    put16(16'h8022);
    put16(16'd20);
    repeat (4) pkt.push_back(8'($urandom));
    set_msg_len(5);
    send_packet();
  endtask

  task automatic test_family_register();
    logic [7:0] codes[3];
    codes = '{8'h00, 8'hFF, 8'h01};
    foreach (codes[i]) begin
      write_family(codes[i]);
      start_stun(STUN_COOKIE);
      put_addr(TYPE_MAPPED, codes[i], 16'($urandom), $urandom, 8);
      put_addr(TYPE_XOR, codes[i] ^ 8'h80, 16'($urandom), $urandom, 8);
      set_msg_len(0);
      send_packet();
      start_stun(STUN_COOKIE);
      put_addr(TYPE_MS_XOR, 8'h01, 16'($urandom), $urandom, 8);
      set_msg_len(0);
      send_packet();
    end
  endtask

  task automatic test_random_packets(input int byte_budget, input int min_reports);
    int sent_bytes = 0;
    int sent_pkts  = 0;
    while (sent_bytes < byte_budget || sent_pkts < min_reports) begin
      if ($urandom_range(9) == 0) wait_drained();
      build_random_packet();
      sent_bytes += pkt.size();
      sent_pkts++;
      send_packet();
    end
  endtask

  initial begin
    clear_parse();
    fam_code = 8'd1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 23;
    recv_idle_pct = 47;
    test_header_checks();
    test_address_attributes();
    test_truncation();
    test_family_register();
    test_random_packets(0, 1);
    send_idle_pct = 47;
    recv_idle_pct = 23;
    write_family(8'($urandom));
    test_random_packets(40, 2);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_family(8'($urandom));
    test_random_packets(40, 2);
    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0 && reports_due.size() == 0) begin
      $display("[stun_mapped_address_extractor] OK");
    end else begin
      $display("[stun_mapped_address_extractor] ERROR");
    end
    $finish;
  end

endmodule
